FILE: rtl/wwatm_pkg.sv
// Shared types, codes and helpers of the whole-word alias table match core.
package wwatm_pkg;

  localparam int ENTRIES_DEF    = 128;
  localparam int TOKEN_LEN_DEF  = 32;
  localparam int QUERY_LEN_DEF  = 256;
  localparam int TARGET_LEN_DEF = 64;

  localparam logic [7:0] SPACE = 8'h20;

  typedef enum logic [2:0] {
    KIND_KEYWORD = 3'd0,
    KIND_TARGET  = 3'd1,
    KIND_QUERY   = 3'd2,
    KIND_CLR_ORG = 3'd3,
    KIND_CLR_ALL = 3'd4
  } kind_t;

  typedef enum logic [2:0] {
    ST_ADDED   = 3'd0,
    ST_FULL    = 3'd1,
    ST_MATCH   = 3'd2,
    ST_NOMATCH = 3'd3,
    ST_CLEARED = 3'd4
  } status_t;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_ACCEPT,
    OP_CL_RD,
    OP_CL_SKIP,
    OP_CL_KEEP,
    OP_CL_META,
    OP_CP_RD,
    OP_CP_WR,
    OP_CL_DONE,
    OP_RS_LD,
    OP_RS_LEN,
    OP_RS_NEXT,
    OP_RS_RD,
    OP_J_INC,
    OP_P_INC,
    OP_RS_LRD,
    OP_RS_RRD,
    OP_EM_INIT,
    OP_EM_EMPTY,
    OP_EM_RD,
    OP_EM_OUT,
    OP_RS_NONE
  } dp_op_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_CL_RD,
    S_CL_CHK,
    S_CP_RD,
    S_CP_WR,
    S_CL_DONE,
    S_RS_LD,
    S_RS_LEN,
    S_RS_SCAN,
    S_RS_CMP,
    S_RS_LCHK,
    S_RS_RCHK,
    S_EM_CHK,
    S_EM_WR,
    S_RS_NONE
  } state_t;

  typedef struct packed {
    dp_op_t op;
  } dp_cmd_t;

  typedef struct packed {
    logic i_done;
    logic keep;
    logic same;
    logic j_last;
    logic s_done;
    logic p_over;
    logic j_eq_k;
    logic eq;
    logic left_ok;
    logic right_ok;
    logic n_zero;
    logic em_last;
  } dp_stat_t;

  function automatic logic [7:0] fold(input logic [7:0] c);
    fold = (c >= 8'h41 && c <= 8'h5A) ? c + 8'd32 : c;
  endfunction

endpackage

FILE: rtl/whole_word_alias_table_match_core.sv
// Top level of the whole-word alias table match core: controller plus datapath.
// Byte, add and clear-all requests end at acceptance; a result strobes in the cycle after it.
// Clear by origin: checks each entry's metadata and copies all TOKEN_LEN bytes of a moved entry.
//   Resolve: a read and a compare per byte; a match then reads out one target byte per result.
// Throughput: one request at a time, busy high during clear and resolve walks; no result stall.
// Reset (rst, synchronous): empties the table, query and pending entry; no clearing pass.
module whole_word_alias_table_match_core #(
  parameter int ENTRIES    = wwatm_pkg::ENTRIES_DEF,
  parameter int TOKEN_LEN  = wwatm_pkg::TOKEN_LEN_DEF,
  parameter int QUERY_LEN  = wwatm_pkg::QUERY_LEN_DEF,
  parameter int TARGET_LEN = wwatm_pkg::TARGET_LEN_DEF
) (
  input  logic       clk,
  input  logic       rst,
  // request side
  input  logic       start,
  output logic       busy,
  input  logic [2:0] kind,
  input  logic [7:0] char_in,
  input  logic       final_char,
  input  logic [1:0] rule_origin,
  // result side
  output logic       strobe,
  output logic [2:0] status,
  output logic [6:0] entry_index,
  output logic [1:0] origin_out,
  output logic [7:0] out_char,
  output logic       last_out
);

  wwatm_pkg::dp_cmd_t  cmd;
  wwatm_pkg::dp_stat_t stat;

  // Sequencer: one state per memory read / compare step of each walk.
  wwatm_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .kind       (kind),
    .final_char (final_char),
    .stat       (stat),
    .cmd        (cmd),
    .busy       (busy)
  );

  // Stores (keyword, target, query, per-entry lengths/origin) and the walk counters.
  wwatm_dp #(
    .ENTRIES    (ENTRIES),
    .TOKEN_LEN  (TOKEN_LEN),
    .QUERY_LEN  (QUERY_LEN),
    .TARGET_LEN (TARGET_LEN)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .kind        (kind),
    .char_in     (char_in),
    .final_char  (final_char),
    .rule_origin (rule_origin),
    .cmd         (cmd),
    .stat        (stat),
    .strobe      (strobe),
    .status      (status),
    .entry_index (entry_index),
    .origin_out  (origin_out),
    .out_char    (out_char),
    .last_out    (last_out)
  );

  // A resolving query holds off the next request.
  a_query_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy && kind == wwatm_pkg::KIND_QUERY && final_char |=> busy)
    else $error("resolve did not raise busy");

  // Only a match produces more than one result; the next assertion checks the spacing of its target bytes.
  a_multi_match: assert property (@(posedge clk) disable iff (rst)
    strobe && !last_out |-> status == wwatm_pkg::ST_MATCH)
    else $error("non-final result that is not a match");

  a_multi_cadence: assert property (@(posedge clk) disable iff (rst)
    strobe && !last_out |-> ##2 strobe)
    else $error("gap in target byte stream");

  // The block is idle again once the last result of a request goes out.
  a_last_idle: assert property (@(posedge clk) disable iff (rst)
    strobe && last_out && status == wwatm_pkg::ST_MATCH |-> !busy)
    else $error("busy after final match result");

endmodule

FILE: rtl/wwatm_ctrl.sv
// Controller state machine: sequences requests, clear walk, resolve walk and emit.
module wwatm_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [2:0]         kind,
  input  logic               final_char,
  input  wwatm_pkg::dp_stat_t stat,
  output wwatm_pkg::dp_cmd_t  cmd,
  output logic               busy
);

  wwatm_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= wwatm_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd.op     = wwatm_pkg::OP_NONE;
    case (state)
      wwatm_pkg::S_IDLE: begin
        if (start) begin
          cmd.op = wwatm_pkg::OP_ACCEPT;
          if (kind == wwatm_pkg::KIND_QUERY && final_char) begin
            state_next = wwatm_pkg::S_RS_LD;
          end else if (kind == wwatm_pkg::KIND_CLR_ORG) begin
            state_next = wwatm_pkg::S_CL_RD;
          end
        end
      end
      wwatm_pkg::S_CL_RD: begin
        cmd.op     = wwatm_pkg::OP_CL_RD;
        state_next = stat.i_done ? wwatm_pkg::S_CL_DONE : wwatm_pkg::S_CL_CHK;
      end
      wwatm_pkg::S_CL_CHK: begin
        state_next = wwatm_pkg::S_CL_RD;
        if (!stat.keep) begin
          cmd.op = wwatm_pkg::OP_CL_SKIP;
        end else if (stat.same) begin
          cmd.op = wwatm_pkg::OP_CL_KEEP;
        end else begin
          cmd.op     = wwatm_pkg::OP_CL_META;
          state_next = wwatm_pkg::S_CP_RD;
        end
      end
      wwatm_pkg::S_CP_RD: begin
        cmd.op     = wwatm_pkg::OP_CP_RD;
        state_next = wwatm_pkg::S_CP_WR;
      end
      wwatm_pkg::S_CP_WR: begin
        cmd.op     = wwatm_pkg::OP_CP_WR;
        state_next = stat.j_last ? wwatm_pkg::S_CL_RD : wwatm_pkg::S_CP_RD;
      end
      wwatm_pkg::S_CL_DONE: begin
        cmd.op     = wwatm_pkg::OP_CL_DONE;
        state_next = wwatm_pkg::S_IDLE;
      end
      wwatm_pkg::S_RS_LD: begin
        cmd.op     = wwatm_pkg::OP_RS_LD;
        state_next = stat.s_done ? wwatm_pkg::S_RS_NONE : wwatm_pkg::S_RS_LEN;
      end
      wwatm_pkg::S_RS_LEN: begin
        cmd.op     = wwatm_pkg::OP_RS_LEN;
        state_next = wwatm_pkg::S_RS_SCAN;
      end
      wwatm_pkg::S_RS_SCAN: begin
        if (stat.j_eq_k) begin
          cmd.op     = wwatm_pkg::OP_RS_LRD;
          state_next = wwatm_pkg::S_RS_LCHK;
        end else if (stat.p_over) begin
          cmd.op     = wwatm_pkg::OP_RS_NEXT;
          state_next = wwatm_pkg::S_RS_LD;
        end else begin
          cmd.op     = wwatm_pkg::OP_RS_RD;
          state_next = wwatm_pkg::S_RS_CMP;
        end
      end
      wwatm_pkg::S_RS_CMP: begin
        cmd.op     = stat.eq ? wwatm_pkg::OP_J_INC : wwatm_pkg::OP_P_INC;
        state_next = wwatm_pkg::S_RS_SCAN;
      end
      wwatm_pkg::S_RS_LCHK: begin
        if (stat.left_ok) begin
          cmd.op     = wwatm_pkg::OP_RS_RRD;
          state_next = wwatm_pkg::S_RS_RCHK;
        end else begin
          cmd.op     = wwatm_pkg::OP_RS_NEXT;
          state_next = wwatm_pkg::S_RS_LD;
        end
      end
      wwatm_pkg::S_RS_RCHK: begin
        if (stat.right_ok) begin
          cmd.op     = wwatm_pkg::OP_EM_INIT;
          state_next = wwatm_pkg::S_EM_CHK;
        end else begin
          cmd.op     = wwatm_pkg::OP_RS_NEXT;
          state_next = wwatm_pkg::S_RS_LD;
        end
      end
      wwatm_pkg::S_EM_CHK: begin
        if (stat.n_zero) begin
          cmd.op     = wwatm_pkg::OP_EM_EMPTY;
          state_next = wwatm_pkg::S_IDLE;
        end else begin
          cmd.op     = wwatm_pkg::OP_EM_RD;
          state_next = wwatm_pkg::S_EM_WR;
        end
      end
      wwatm_pkg::S_EM_WR: begin
        cmd.op     = wwatm_pkg::OP_EM_OUT;
        state_next = stat.em_last ? wwatm_pkg::S_IDLE : wwatm_pkg::S_EM_CHK;
      end
      wwatm_pkg::S_RS_NONE: begin
        cmd.op     = wwatm_pkg::OP_RS_NONE;
        state_next = wwatm_pkg::S_IDLE;
      end
      default: begin
        state_next = wwatm_pkg::S_IDLE;
      end
    endcase
  end

  assign busy = (state != wwatm_pkg::S_IDLE);

endmodule

FILE: rtl/wwatm_dp.sv
// Datapath: entry and query stores, walk counters, compare logic, result registers.
module wwatm_dp #(
  parameter int ENTRIES    = wwatm_pkg::ENTRIES_DEF,
  parameter int TOKEN_LEN  = wwatm_pkg::TOKEN_LEN_DEF,
  parameter int QUERY_LEN  = wwatm_pkg::QUERY_LEN_DEF,
  parameter int TARGET_LEN = wwatm_pkg::TARGET_LEN_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic [2:0]          kind,
  input  logic [7:0]          char_in,
  input  logic                final_char,
  input  logic [1:0]          rule_origin,
  input  wwatm_pkg::dp_cmd_t  cmd,
  output wwatm_pkg::dp_stat_t stat,
  output logic                strobe,
  output logic [2:0]          status,
  output logic [6:0]          entry_index,
  output logic [1:0]          origin_out,
  output logic [7:0]          out_char,
  output logic                last_out
);

  localparam int SW   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CW   = $clog2(ENTRIES + 1);
  localparam int TW   = $clog2(TOKEN_LEN);
  localparam int QW   = $clog2(QUERY_LEN);
  localparam int AW   = ((QW > TW) ? QW : TW) + 1;
  localparam int MW   = 2 * TW + 2;
  localparam int TCAP = TARGET_LEN - 1;

  // stores
  logic [7:0]    kw_mem   [2**(SW+TW)];
  logic [7:0]    tg_mem   [2**(SW+TW)];
  logic [7:0]    q_mem    [QUERY_LEN];
  logic [MW-1:0] meta_mem [2**SW];

  logic [7:0]    kw_q, tg_q, q_q;
  logic [MW-1:0] meta_q;

  // control registers
  logic [CW-1:0] count, i, w, s;
  logic [QW-1:0] ql, p;
  logic [TW-1:0] pk, pt, j, k, n;
  logic          kc, tc, qc;
  logic [1:0]    org_r, m_org;

  logic acc, room, store_k, store_t, store_q, commit, res_op;
  logic [TW-1:0] pt_new, m_klen, m_tlen, n_cap;
  logic [AW-1:0] pk_sum, pj_sum;
  logic          m_we, kw_we, tg_we, q_we;
  logic [SW-1:0] m_waddr, m_raddr;
  logic [MW-1:0] m_wdata;
  logic [SW+TW-1:0] kw_waddr, tg_waddr, t_raddr;
  logic [7:0]    kw_wdata, tg_wdata;
  logic [QW-1:0] q_raddr;
  logic [CW-1:0] rslot;

  assign acc     = (cmd.op == wwatm_pkg::OP_ACCEPT);
  assign room    = (count < CW'(ENTRIES));
  assign store_k = (kind == wwatm_pkg::KIND_KEYWORD) && !kc && (char_in != 8'd0) && room &&
                   (pk < TW'(TOKEN_LEN - 1));
  assign store_t = (kind == wwatm_pkg::KIND_TARGET) && !tc && (char_in != 8'd0) && room &&
                   (pt < TW'(TOKEN_LEN - 1));
  assign store_q = (kind == wwatm_pkg::KIND_QUERY) && !qc && (char_in != 8'd0) &&
                   (ql < QW'(QUERY_LEN - 1));
  assign commit  = acc && (kind == wwatm_pkg::KIND_TARGET) && final_char && room;
  assign pt_new  = pt + TW'(store_t);

  // every op that puts a result on the ports
  assign res_op  = (acc && ((kind == wwatm_pkg::KIND_TARGET && final_char) ||
                            kind == wwatm_pkg::KIND_CLR_ALL)) ||
                   (cmd.op == wwatm_pkg::OP_CL_DONE) ||
                   (cmd.op == wwatm_pkg::OP_EM_EMPTY) ||
                   (cmd.op == wwatm_pkg::OP_EM_OUT) ||
                   (cmd.op == wwatm_pkg::OP_RS_NONE);

  assign m_klen  = meta_q[MW-1 -: TW];
  assign m_tlen  = meta_q[TW+1 -: TW];
  assign n_cap   = (int'(m_tlen) > TCAP) ? TW'(TCAP) : m_tlen;

  assign pk_sum  = AW'(p) + AW'(k);
  assign pj_sum  = AW'(p) + AW'(j);

  // write ports
  assign m_we     = commit || (cmd.op == wwatm_pkg::OP_CL_META);
  assign m_waddr  = commit ? count[SW-1:0] : w[SW-1:0];
  assign m_wdata  = commit ? {pk, pt_new, rule_origin} : meta_q;
  assign kw_we    = (acc && store_k) || (cmd.op == wwatm_pkg::OP_CP_WR);
  assign kw_waddr = acc ? {count[SW-1:0], pk} : {w[SW-1:0], j};
  assign kw_wdata = acc ? char_in : kw_q;
  assign tg_we    = (acc && store_t) || (cmd.op == wwatm_pkg::OP_CP_WR);
  assign tg_waddr = acc ? {count[SW-1:0], pt} : {w[SW-1:0], j};
  assign tg_wdata = acc ? char_in : tg_q;
  assign q_we     = acc && store_q;

  // read ports
  assign rslot   = (cmd.op == wwatm_pkg::OP_CP_RD) ? i : s;
  assign t_raddr = {rslot[SW-1:0], j};
  assign m_raddr = (cmd.op == wwatm_pkg::OP_CL_RD) ? i[SW-1:0] : s[SW-1:0];

  always_comb begin
    case (cmd.op)
      wwatm_pkg::OP_RS_LRD: q_raddr = p - QW'(1);
      wwatm_pkg::OP_RS_RRD: q_raddr = pk_sum[QW-1:0];
      default:              q_raddr = pj_sum[QW-1:0];
    endcase
  end

  always_ff @(posedge clk) begin
    if (m_we) begin
      meta_mem[m_waddr] <= m_wdata;
    end
    if (kw_we) begin
      kw_mem[kw_waddr] <= kw_wdata;
    end
    if (tg_we) begin
      tg_mem[tg_waddr] <= tg_wdata;
    end
    if (q_we) begin
      q_mem[ql] <= char_in;
    end
    meta_q <= meta_mem[m_raddr];
    kw_q   <= kw_mem[t_raddr];
    tg_q   <= tg_mem[t_raddr];
    q_q    <= q_mem[q_raddr];
  end

  // status back to the controller
  assign stat.i_done   = (i == count);
  assign stat.keep     = (meta_q[1:0] != org_r);
  assign stat.same     = (i == w);
  assign stat.j_last   = (j == TW'(TOKEN_LEN - 1));
  assign stat.s_done   = (s == count);
  assign stat.p_over   = (pk_sum > AW'(ql));
  assign stat.j_eq_k   = (j == k);
  assign stat.eq       = (wwatm_pkg::fold(q_q) == wwatm_pkg::fold(kw_q));
  assign stat.left_ok  = (p == '0) || (q_q == wwatm_pkg::SPACE);
  assign stat.right_ok = (pk_sum == AW'(ql)) || (q_q == wwatm_pkg::SPACE);
  assign stat.n_zero   = (n == '0);
  assign stat.em_last  = (j == n - TW'(1));

  // result strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      strobe <= 1'b0;
    end else begin
      strobe <= res_op;
    end
  end

  // counters, flags
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      ql    <= '0;
      pk    <= '0;
      pt    <= '0;
      kc    <= 1'b0;
      tc    <= 1'b0;
      qc    <= 1'b0;
    end else begin
      case (cmd.op)
        wwatm_pkg::OP_ACCEPT: begin
          org_r <= rule_origin;
          case (kind)
            wwatm_pkg::KIND_KEYWORD: begin
              if ((!kc && char_in == 8'd0) || final_char) kc <= 1'b1;
              if (store_k) pk <= pk + TW'(1);
            end
            wwatm_pkg::KIND_TARGET: begin
              if (final_char) begin
                pk <= '0;
                pt <= '0;
                kc <= 1'b0;
                tc <= 1'b0;
                status      <= room ? wwatm_pkg::ST_ADDED : wwatm_pkg::ST_FULL;
                entry_index <= room ? 7'(count) : 7'd0;
                origin_out  <= 2'd0;
                out_char    <= 8'd0;
                last_out    <= 1'b1;
                if (room) count <= count + CW'(1);
              end else begin
                if (!tc && char_in == 8'd0) tc <= 1'b1;
                if (store_t) pt <= pt + TW'(1);
              end
            end
            wwatm_pkg::KIND_QUERY: begin
              if (!qc && char_in == 8'd0) qc <= 1'b1;
              if (store_q) ql <= ql + QW'(1);
              if (final_char) s <= '0;
            end
            wwatm_pkg::KIND_CLR_ORG: begin
              pk <= '0;
              pt <= '0;
              kc <= 1'b0;
              tc <= 1'b0;
              i  <= '0;
              w  <= '0;
            end
            wwatm_pkg::KIND_CLR_ALL: begin
              count <= '0;
              pk <= '0;
              pt <= '0;
              kc <= 1'b0;
              tc <= 1'b0;
              status      <= wwatm_pkg::ST_CLEARED;
              entry_index <= 7'd0;
              origin_out  <= 2'd0;
              out_char    <= 8'd0;
              last_out    <= 1'b1;
            end
            default: begin
            end
          endcase
        end
        wwatm_pkg::OP_CL_SKIP: i <= i + CW'(1);
        wwatm_pkg::OP_CL_KEEP: begin
          i <= i + CW'(1);
          w <= w + CW'(1);
        end
        wwatm_pkg::OP_CL_META: j <= '0;
        wwatm_pkg::OP_CP_WR: begin
          if (stat.j_last) begin
            j <= '0;
            i <= i + CW'(1);
            w <= w + CW'(1);
          end else begin
            j <= j + TW'(1);
          end
        end
        wwatm_pkg::OP_CL_DONE: begin
          count       <= w;
          status      <= wwatm_pkg::ST_CLEARED;
          entry_index <= 7'd0;
          origin_out  <= 2'd0;
          out_char    <= 8'd0;
          last_out    <= 1'b1;
        end
        wwatm_pkg::OP_RS_LEN: begin
          k     <= m_klen;
          n     <= n_cap;
          m_org <= meta_q[1:0];
          p     <= '0;
          j     <= '0;
        end
        wwatm_pkg::OP_RS_NEXT: s <= s + CW'(1);
        wwatm_pkg::OP_J_INC:   j <= j + TW'(1);
        wwatm_pkg::OP_P_INC: begin
          p <= p + QW'(1);
          j <= '0;
        end
        wwatm_pkg::OP_EM_INIT: j <= '0;
        wwatm_pkg::OP_EM_EMPTY: begin
          ql          <= '0;
          qc          <= 1'b0;
          status      <= wwatm_pkg::ST_MATCH;
          entry_index <= 7'(s);
          origin_out  <= m_org;
          out_char    <= 8'd0;
          last_out    <= 1'b1;
        end
        wwatm_pkg::OP_EM_OUT: begin
          j           <= j + TW'(1);
          status      <= wwatm_pkg::ST_MATCH;
          entry_index <= 7'(s);
          origin_out  <= m_org;
          out_char    <= tg_q;
          last_out    <= stat.em_last;
          if (stat.em_last) begin
            ql <= '0;
            qc <= 1'b0;
          end
        end
        wwatm_pkg::OP_RS_NONE: begin
          ql          <= '0;
          qc          <= 1'b0;
          status      <= wwatm_pkg::ST_NOMATCH;
          entry_index <= 7'd0;
          origin_out  <= 2'd0;
          out_char    <= 8'd0;
          last_out    <= 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

endmodule

FILE: tb/sv/wwatm_checker.sv
`timescale 1ns / 100ps
// Checker for the alias table match core: predicts results of each request and compares them.
module wwatm_checker (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  input  logic       busy,
  input  logic [2:0] kind,
  input  logic [7:0] char_in,
  input  logic       final_char,
  input  logic [1:0] rule_origin,
  input  logic       strobe,
  input  logic [2:0] status,
  input  logic [6:0] entry_index,
  input  logic [1:0] origin_out,
  input  logic [7:0] out_char,
  input  logic       last_out,
  output int         fails,
  output int         pending,
  output int         n_req,
  output int         n_res,
  output int         n_match,
  output int         n_full
);

  localparam int NENT = wwatm_pkg::ENTRIES_DEF;
  localparam int TOK  = wwatm_pkg::TOKEN_LEN_DEF;
  localparam int QLEN = wwatm_pkg::QUERY_LEN_DEF;
  localparam int TLEN = wwatm_pkg::TARGET_LEN_DEF;

  typedef struct {
    wwatm_pkg::status_t st;
    logic [6:0]         idx;
    logic [1:0]         org;
    logic [7:0]         ch;
    logic               last;
  } answer_t;

  answer_t answers_due[$];

  // shadow table
  logic [7:0] kw_txt [NENT][TOK];
  int         kw_len [NENT];
  logic [7:0] tg_txt [NENT][TOK];
  int         tg_len [NENT];
  logic [1:0] ent_org [NENT];
  int         ent_cnt;
  logic [7:0] q_txt [QLEN];
  int         q_len, pk_len, pt_len;
  bit         kw_closed, tg_closed, q_closed;

  function automatic logic [7:0] lower_ascii(logic [7:0] c);
    return (c >= "A" && c <= "Z") ? c + 8'd32 : c;
  endfunction

  function automatic void queue_answer(wwatm_pkg::status_t st, int idx, logic [1:0] org,
                                       logic [7:0] ch, logic last);
    answer_t a;
    a.st = st; a.idx = idx[6:0]; a.org = org; a.ch = ch; a.last = last;
    answers_due.push_back(a);
  endfunction

  // first occurrence only, then word bounds
  function automatic bit entry_hits(int s);
    int k, j;
    k = kw_len[s];
    if (k > q_len) return 0;
    for (int p = 0; p + k <= q_len; p++) begin
      for (j = 0; j < k; j++)
        if (lower_ascii(q_txt[p + j]) != lower_ascii(kw_txt[s][j])) break;
      if (j == k)
        return (p == 0 || q_txt[p - 1] == wwatm_pkg::SPACE) &&
               (p + k == q_len || q_txt[p + k] == wwatm_pkg::SPACE);
    end
    return 0;
  endfunction

  function automatic void drop_entry_in_work();
    pk_len = 0; pt_len = 0; kw_closed = 0; tg_closed = 0;
  endfunction

  function automatic void resolve_query();
    int n;
    for (int s = 0; s < ent_cnt; s++) begin
      if (!entry_hits(s)) continue;
      n = (tg_len[s] > TLEN - 1) ? TLEN - 1 : tg_len[s];
      n_match++;
      if (n == 0) queue_answer(wwatm_pkg::ST_MATCH, s, ent_org[s], 8'd0, 1'b1);
      for (int j = 0; j < n; j++)
        queue_answer(wwatm_pkg::ST_MATCH, s, ent_org[s], tg_txt[s][j], j + 1 == n);
      return;
    end
    queue_answer(wwatm_pkg::ST_NOMATCH, 0, 2'd0, 8'd0, 1'b1);
  endfunction

  function automatic void predict_request(logic [2:0] k, logic [7:0] c, logic fin,
                                          logic [1:0] org);
    bit room;
    int w;
    room = ent_cnt < NENT;
    case (k)
      wwatm_pkg::KIND_KEYWORD: begin
        if (!kw_closed) begin
          if (c == 0) kw_closed = 1;
          else if (room && pk_len < TOK - 1) begin
            kw_txt[ent_cnt][pk_len] = c;
            pk_len++;
          end
        end
        if (fin) kw_closed = 1;
      end
      wwatm_pkg::KIND_TARGET: begin
        if (!tg_closed) begin
          if (c == 0) tg_closed = 1;
          else if (room && pt_len < TOK - 1) begin
            tg_txt[ent_cnt][pt_len] = c;
            pt_len++;
          end
        end
        if (fin) begin
          if (!room) begin
            n_full++;
            queue_answer(wwatm_pkg::ST_FULL, 0, 2'd0, 8'd0, 1'b1);
          end else begin
            kw_len[ent_cnt] = pk_len;
            tg_len[ent_cnt] = pt_len;
            ent_org[ent_cnt] = org;
            queue_answer(wwatm_pkg::ST_ADDED, ent_cnt, 2'd0, 8'd0, 1'b1);
            ent_cnt++;
          end
          drop_entry_in_work();
        end
      end
      wwatm_pkg::KIND_QUERY: begin
        if (!q_closed) begin
          if (c == 0) q_closed = 1;
          else if (q_len < QLEN - 1) begin
            q_txt[q_len] = c;
            q_len++;
          end
        end
        if (fin) begin
          resolve_query();
          q_len = 0;
          q_closed = 0;
        end
      end
      wwatm_pkg::KIND_CLR_ORG: begin
        // compact survivors, order kept
        w = 0;
        for (int i = 0; i < ent_cnt; i++)
          if (ent_org[i] != org) begin
            kw_txt[w] = kw_txt[i]; tg_txt[w] = tg_txt[i];
            kw_len[w] = kw_len[i]; tg_len[w] = tg_len[i];
            ent_org[w] = ent_org[i];
            w++;
          end
        ent_cnt = w;
        drop_entry_in_work();
        queue_answer(wwatm_pkg::ST_CLEARED, 0, 2'd0, 8'd0, 1'b1);
      end
      wwatm_pkg::KIND_CLR_ALL: begin
        ent_cnt = 0;
        drop_entry_in_work();
        queue_answer(wwatm_pkg::ST_CLEARED, 0, 2'd0, 8'd0, 1'b1);
      end
      default: ;
    endcase
  endfunction

  initial begin
    fails = 0; pending = 0; n_req = 0; n_res = 0; n_match = 0; n_full = 0;
  end

  always @(posedge clk) begin
    answer_t a;
    if (rst) begin
      answers_due.delete();
      ent_cnt = 0; q_len = 0; q_closed = 0;
      drop_entry_in_work();
    end else begin
      if (strobe) begin
        n_res++;
        if (answers_due.size() == 0) begin
          $error("unexpected result: status %0d index %0d char %0h", status, entry_index,
                 out_char);
          fails++;
        end else begin
          a = answers_due.pop_front();
          if (status !== a.st) begin
            $error("status: expected %0d, got %0d", a.st, status); fails++;
          end
          if (entry_index !== a.idx) begin
            $error("entry_index: expected %0d, got %0d", a.idx, entry_index); fails++;
          end
          if (origin_out !== a.org) begin
            $error("origin_out: expected %0d, got %0d", a.org, origin_out); fails++;
          end
          if (out_char !== a.ch) begin
            $error("out_char: expected %0h, got %0h", a.ch, out_char); fails++;
          end
          if (last_out !== a.last) begin
            $error("last_out: expected %0d, got %0d", a.last, last_out); fails++;
          end
        end
      end
      if (start && !busy) begin
        n_req++;
        predict_request(kind, char_in, final_char, rule_origin);
      end
    end
    pending = answers_due.size();
  end

endmodule

FILE: tb/sv/tb_whole_word_alias_table_match_core.sv
`timescale 1ns / 100ps
// Testbench top for the alias table match core: stimulus, watchdog and verdict.
module tb_whole_word_alias_table_match_core;

  // no request or result for this long means the core hung
  localparam int STALL_LIMIT = 100000;

  logic       clk, rst, start, busy;
  logic [2:0] kind;
  logic [7:0] char_in;
  logic       final_char;
  logic [1:0] rule_origin;
  logic       strobe;
  logic [2:0] status;
  logic [6:0] entry_index;
  logic [1:0] origin_out;
  logic [7:0] out_char;
  logic       last_out;

  int fails, pending, n_req, n_res, n_match, n_full;
  int gap_pct;
  int quiet_cycles;

  string words[8] = '{"cat", "Dog", "ls", "go", "x", "alias", "run", "Vi"};

  whole_word_alias_table_match_core uut (
    .clk, .rst, .start, .busy, .kind, .char_in, .final_char, .rule_origin,
    .strobe, .status, .entry_index, .origin_out, .out_char, .last_out
  );

  wwatm_checker chk (
    .clk, .rst, .start, .busy, .kind, .char_in, .final_char, .rule_origin,
    .strobe, .status, .entry_index, .origin_out, .out_char, .last_out,
    .fails, .pending, .n_req, .n_res, .n_match, .n_full
  );

  initial begin
    clk = 0;
    forever #4 clk = ~clk;
  end

  // Watchdog: counts cycles where neither a request nor a result moves.
  always @(posedge clk) begin
    if (rst || (start && !busy) || strobe) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("[whole_word_alias_table_match_core] ERROR");
      $finish;
    end
  end

  // One request. Called at a falling edge; returns at the falling edge after acceptance.
  // busy only moves at rising edges, so its value here holds up to the next one.
  task automatic issue(input logic [2:0] k, input logic [7:0] c, input logic f,
                       input logic [1:0] o);
    bit taken;
    if (gap_pct > 0 && $urandom_range(99) < gap_pct) begin
      start = 0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
    end
    kind = k; char_in = c; final_char = f; rule_origin = o;
    start = 1;
    forever begin
      taken = !busy;
      @(posedge clk);
      @(negedge clk);
      if (taken) break;
    end
  endtask

  // Sends a string; an empty string becomes a lone terminator byte.
  // The byte at position cut, if any, is sent as a terminator.
  task automatic issue_str(input logic [2:0] k, input string s, input bit fin,
                           input logic [1:0] o, input int cut = -1);
    if (s.len() == 0) issue(k, 8'd0, fin, o);
    for (int i = 0; i < s.len(); i++)
      issue(k, (i == cut) ? 8'd0 : 8'(s[i]), fin && i == s.len() - 1, o);
  endtask

  task automatic add_entry(input string kw, input string tg, input logic [1:0] o);
    if (kw.len() > 0) issue_str(wwatm_pkg::KIND_KEYWORD, kw, 1'b1, o);
    issue_str(wwatm_pkg::KIND_TARGET, tg, 1'b1, o);
  endtask

  function automatic string mix_case(input string s);
    string r;
    r = s;
    for (int i = 0; i < r.len(); i++)
      if ($urandom_range(1)) begin
        if (r[i] >= "a" && r[i] <= "z") r[i] = r[i] - 8'd32;
        else if (r[i] >= "A" && r[i] <= "Z") r[i] = r[i] + 8'd32;
      end
    return r;
  endfunction

  function automatic string rand_bytes(input int n);
    string r;
    r = "";
    for (int i = 0; i < n; i++) r = {r, " "};
    for (int i = 0; i < n; i++) r[i] = 8'($urandom_range(1, 255));
    return r;
  endfunction

  // Query of a few pool words; sometimes glued to letters so the word bounds fail.
  function automatic string rand_query();
    string q;
    q = ($urandom_range(7) == 0) ? " " : "";
    repeat ($urandom_range(1, 4)) begin
      if ($urandom_range(5) == 0) q = {q, "z"};
      q = {q, mix_case(words[$urandom_range(7)])};
      if ($urandom_range(5) == 0) q = {q, "s"};
      q = {q, " "};
    end
    if ($urandom_range(1)) q = q.substr(0, q.len() - 2);
    return q;
  endfunction

  task automatic random_request();
    int pick;
    int cut;
    string s;
    pick = $urandom_range(99);
    if (pick < 38) begin
      s = ($urandom_range(9) == 0) ? "" : mix_case(words[$urandom_range(7)]);
      if ($urandom_range(9) == 0) s = rand_bytes($urandom_range(1, 4));
      add_entry(s, ($urandom_range(7) == 0) ? "" : rand_bytes($urandom_range(1, 6)),
                2'($urandom_range(3)));
    end else if (pick < 72) begin
      s = ($urandom_range(9) == 0) ? rand_bytes($urandom_range(1, 8)) : rand_query();
      // a terminator at a random position cuts the query short
      cut = ($urandom_range(11) == 0) ? int'($urandom_range(s.len() - 1)) : -1;
      issue_str(wwatm_pkg::KIND_QUERY, s, 1'b1, 2'($urandom_range(3)), cut);
    end else if (pick < 80) begin
      issue(wwatm_pkg::KIND_CLR_ORG, 8'($urandom_range(255)), 1'($urandom_range(1)),
            2'($urandom_range(3)));
    end else if (pick < 84) begin
      issue(wwatm_pkg::KIND_CLR_ALL, 8'($urandom_range(255)), 1'($urandom_range(1)),
            2'($urandom_range(3)));
    end else if (pick < 92) begin
      // broken entry: a keyword byte with no commit, left to a later target
      issue(wwatm_pkg::KIND_KEYWORD, 8'($urandom_range(255)), 1'($urandom_range(1)),
            2'($urandom_range(3)));
    end else begin
      issue(3'($urandom_range(5, 7)), 8'($urandom_range(255)), 1'($urandom_range(1)),
            2'($urandom_range(3)));
    end
  endtask

  initial begin
    rst = 1; start = 0; kind = 0; char_in = 0; final_char = 0; rule_origin = 0;
    gap_pct = 0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 0;

    // Directed: empty table, empty keyword, empty target, case folding, bounds
    issue(wwatm_pkg::KIND_CLR_ALL, 8'h00, 1'b0, 2'd0);
    issue(wwatm_pkg::KIND_QUERY, 8'h00, 1'b1, 2'd0);
    add_entry("", "Nul", 2'd3);
    issue_str(wwatm_pkg::KIND_QUERY, " hi", 1'b1, 2'd0);
    issue(wwatm_pkg::KIND_QUERY, 8'h00, 1'b1, 2'd0);
    add_entry("Ab", "", 2'd1);
    issue_str(wwatm_pkg::KIND_QUERY, "xx aB", 1'b1, 2'd2);
    issue_str(wwatm_pkg::KIND_QUERY, "xab ab", 1'b1, 2'd0);
    issue(wwatm_pkg::KIND_KEYWORD, 8'hFF, 1'b0, 2'd0);
    issue(wwatm_pkg::KIND_KEYWORD, 8'h80, 1'b1, 2'd0);
    issue(wwatm_pkg::KIND_TARGET, 8'hFF, 1'b1, 2'd2);
    issue(wwatm_pkg::KIND_QUERY, 8'hFF, 1'b0, 2'd0);
    issue(wwatm_pkg::KIND_QUERY, 8'h80, 1'b1, 2'd0);
    issue(wwatm_pkg::KIND_CLR_ORG, 8'h00, 1'b0, 2'd3);
    // overlong target is cut to its buffer; the match sends the longest burst
    add_entry("k", {"ABCDEFGHIJKLMNOPQRSTUVWXYZABCDEF", "G"}, 2'd0);
    issue_str(wwatm_pkg::KIND_QUERY, "k", 1'b1, 2'd0);
    // clears drop a half-built entry but keep a query in progress
    issue(wwatm_pkg::KIND_KEYWORD, "g", 1'b0, 2'd0);
    issue(wwatm_pkg::KIND_CLR_ALL, 8'h00, 1'b0, 2'd0);
    issue(wwatm_pkg::KIND_QUERY, "g", 1'b0, 2'd0);
    issue(wwatm_pkg::KIND_TARGET, "T", 1'b1, 2'd1);
    issue(wwatm_pkg::KIND_CLR_ORG, 8'h00, 1'b0, 2'd2);
    issue(wwatm_pkg::KIND_QUERY, 8'h00, 1'b1, 2'd0);
    for (int k = 5; k < 8; k++) issue(3'(k), 8'h5A, 1'b1, 2'd3);

    // Fill the table to the last slot with empty-keyword entries, then overflow it
    issue(wwatm_pkg::KIND_CLR_ALL, 8'h00, 1'b0, 2'd0);
    for (int i = 0; i < wwatm_pkg::ENTRIES_DEF; i++) begin
      issue(wwatm_pkg::KIND_TARGET, 8'($urandom_range(1, 255)), 1'b1,
            2'($urandom_range(3)));
    end
    issue(wwatm_pkg::KIND_KEYWORD, "q", 1'b1, 2'd0);
    issue(wwatm_pkg::KIND_TARGET, "Q", 1'b1, 2'd0);
    issue_str(wwatm_pkg::KIND_QUERY, "q", 1'b1, 2'd0);
    issue(wwatm_pkg::KIND_CLR_ORG, 8'h00, 1'b0, 2'd2);
    issue_str(wwatm_pkg::KIND_QUERY, " ", 1'b1, 2'd0);
    issue(wwatm_pkg::KIND_CLR_ALL, 8'h00, 1'b0, 2'd0);

    // Random: three thirds with different sender gap rates
    for (int i = 0; i < 21; i++) begin
      gap_pct = (i < 7) ? 36 : (i < 14) ? 51 : 0;
      random_request();
    end

    start = 0;
    while (pending != 0) @(posedge clk);
    repeat (64) @(posedge clk);

    $display("Covered %0d requests and %0d results: %0d matches, %0d table-full answers,",
             n_req, n_res, n_match, n_full);
    $display("with clears, an overlong target, empty keys/targets and sender gaps.");
    if (fails == 0) begin
      $display("[whole_word_alias_table_match_core] OK");
    end else begin
      $display("[whole_word_alias_table_match_core] ERROR");
    end
    $finish;
  end

endmodule
